[src/dtsp_pkg.sv]
// Package for the date-time text parser.
// Holds the text layout constants, the result record and the month length table.
// No dependencies.
`default_nettype none

package dtsp_pkg;

    localparam int unsigned MSG_LEN   = 17;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned FIELD_W   = 6;
    localparam int unsigned NUM_FIELDS = 6;
    localparam int unsigned IDX_W     = 3;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MSG_LEN);

    // Separator offsets within the text
    localparam logic [POS_W-1:0] POS_DASH_A  = 5'd2;
    localparam logic [POS_W-1:0] POS_DASH_B  = 5'd5;
    localparam logic [POS_W-1:0] POS_SPACE   = 5'd8;
    localparam logic [POS_W-1:0] POS_COLON_A = 5'd11;
    localparam logic [POS_W-1:0] POS_COLON_B = 5'd14;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [FIELD_W-1:0] MAX_PAIR   = 6'd59;
    localparam logic [FIELD_W-1:0] MAX_MONTH  = 6'd12;
    localparam logic [FIELD_W-1:0] MAX_HOUR   = 6'd23;
    localparam logic [FIELD_W-1:0] MONTH_FEB  = 6'd2;
    localparam logic [FIELD_W-1:0] LEAP_FEB   = 6'd29;

    localparam logic [IDX_W-1:0] IDX_YEAR   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_MONTH  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_DAY    = 3'd2;
    localparam logic [IDX_W-1:0] IDX_HOUR   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_MINUTE = 3'd4;
    localparam logic [IDX_W-1:0] IDX_SECOND = 3'd5;

    typedef struct packed {
        logic               valid_res;
        logic [5:0]         year;
        logic [3:0]         month;
        logic [5:0]         day;
        logic [5:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
    } result_t;

    // Days in a non-leap month; index 0 and codes above 12 are never used as valid
    function automatic logic [FIELD_W-1:0] month_days(input logic [3:0] mo);
        logic [FIELD_W-1:0] d;
        case (mo)
            4'd1:    d = 6'd31;
            4'd2:    d = 6'd28;
            4'd3:    d = 6'd31;
            4'd4:    d = 6'd30;
            4'd5:    d = 6'd31;
            4'd6:    d = 6'd30;
            4'd7:    d = 6'd31;
            4'd8:    d = 6'd31;
            4'd9:    d = 6'd30;
            4'd10:   d = 6'd31;
            4'd11:   d = 6'd30;
            4'd12:   d = 6'd31;
            default: d = 6'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[src/datetime_string_parser_unit.sv]
// Top level of the date-time text parser: character scanner, pair conversion,
// final range checks and a two-deep result buffer. Depends on dtsp_pkg.
`default_nettype none

// Parses "YY-MM-DD hh:mm:ss" text arriving one character per input transfer.
// The input sustains one transfer per clock while it is not stalled;
// separators and digit pairs are checked as they arrive, and on the
// character flagged end_of_text one result is registered on the next edge.
// The result side holds an output register plus one skid entry, so input
// keeps flowing while a result waits; input stalls only when both entries
// are occupied. An invalid message returns valid_res low with all fields
// zero. Per-message state clears after the final character.
module datetime_string_parser_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_end_of_text,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_valid_res,
    output logic [5:0]      m_year,
    output logic [3:0]      m_month,
    output logic [5:0]      m_day,
    output logic [5:0]      m_hour,
    output logic [5:0]      m_minute,
    output logic [5:0]      m_second
);

    localparam int unsigned POS_W   = dtsp_pkg::POS_W;
    localparam int unsigned FIELD_W = dtsp_pkg::FIELD_W;
    localparam int unsigned IDX_W   = dtsp_pkg::IDX_W;

    logic [POS_W-1:0]   char_position_reg, char_position_next;
    logic               too_long_reg, too_long_next;
    logic               error_seen_reg, error_seen_next;
    logic [7:0]         tens_char_reg, tens_char_next;
    logic [FIELD_W-1:0] field_values_reg  [dtsp_pkg::NUM_FIELDS];
    logic [FIELD_W-1:0] field_values_next [dtsp_pkg::NUM_FIELDS];

    logic               main_valid_reg, skid_valid_reg;
    dtsp_pkg::result_t  main_res_reg, skid_res_reg;
    dtsp_pkg::result_t  new_res;

    logic               s_fire, m_fire, push;

    // Pair conversion
    logic [7:0]         tens_digit, units_digit;
    logic signed [11:0] tens_ext, units_ext, pair_sum;
    logic               pair_ok;
    logic [IDX_W-1:0]   unit_idx;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = main_valid_reg && m_ready;
    assign push    = s_fire && s_end_of_text;

    assign tens_digit  = tens_char_reg - dtsp_pkg::CHAR_ZERO;
    assign units_digit = s_char_in - dtsp_pkg::CHAR_ZERO;
    assign tens_ext    = {{4{tens_digit[7]}}, tens_digit};
    assign units_ext   = {{4{units_digit[7]}}, units_digit};
    assign pair_sum    = tens_ext * 12'sd10 + units_ext;
    assign pair_ok     = !pair_sum[11] && (pair_sum[10:0] <= 11'(dtsp_pkg::MAX_PAIR));

    // Which field a units character at this offset completes
    always_comb begin
        case (char_position_reg)
            5'd1:    unit_idx = dtsp_pkg::IDX_YEAR;
            5'd4:    unit_idx = dtsp_pkg::IDX_MONTH;
            5'd7:    unit_idx = dtsp_pkg::IDX_DAY;
            5'd10:   unit_idx = dtsp_pkg::IDX_HOUR;
            5'd13:   unit_idx = dtsp_pkg::IDX_MINUTE;
            default: unit_idx = dtsp_pkg::IDX_SECOND;
        endcase
    end

    // Scanner next state for the character being transferred
    always_comb begin
        char_position_next = char_position_reg;
        too_long_next      = too_long_reg;
        error_seen_next    = error_seen_reg;
        tens_char_next     = tens_char_reg;
        field_values_next  = field_values_reg;

        if (char_position_reg >= dtsp_pkg::POS_LAST) begin
            too_long_next = 1'b1;
        end else begin
            case (char_position_reg)
                dtsp_pkg::POS_DASH_A, dtsp_pkg::POS_DASH_B: begin
                    if (s_char_in != dtsp_pkg::CHAR_DASH) error_seen_next = 1'b1;
                end
                dtsp_pkg::POS_SPACE: begin
                    if (s_char_in != dtsp_pkg::CHAR_SPACE) error_seen_next = 1'b1;
                end
                dtsp_pkg::POS_COLON_A, dtsp_pkg::POS_COLON_B: begin
                    if (s_char_in != dtsp_pkg::CHAR_COLON) error_seen_next = 1'b1;
                end
                5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15: begin
                    tens_char_next = s_char_in;
                end
                default: begin
                    if (pair_ok) field_values_next[unit_idx] = pair_sum[FIELD_W-1:0];
                    else         error_seen_next = 1'b1;
                end
            endcase
            char_position_next = char_position_reg + 5'd1;
        end
    end

    // Final checks on the state as it stands after this character
    always_comb begin
        logic [FIELD_W-1:0] yy, mo, dd, hh, mi, ss, lim;
        logic               ok;
        yy  = field_values_next[dtsp_pkg::IDX_YEAR];
        mo  = field_values_next[dtsp_pkg::IDX_MONTH];
        dd  = field_values_next[dtsp_pkg::IDX_DAY];
        hh  = field_values_next[dtsp_pkg::IDX_HOUR];
        mi  = field_values_next[dtsp_pkg::IDX_MINUTE];
        ss  = field_values_next[dtsp_pkg::IDX_SECOND];
        lim = dtsp_pkg::month_days(mo[3:0]);
        // 2000 is a multiple of four, so only the two-digit year matters
        if (mo == dtsp_pkg::MONTH_FEB && yy[1:0] == 2'd0) lim = dtsp_pkg::LEAP_FEB;

        ok = !error_seen_next && !too_long_next
             && (char_position_next == dtsp_pkg::POS_LAST)
             && (mo != '0) && (mo <= dtsp_pkg::MAX_MONTH)
             && (dd != '0) && (dd <= lim)
             && (hh <= dtsp_pkg::MAX_HOUR)
             && (mi <= dtsp_pkg::MAX_PAIR) && (ss <= dtsp_pkg::MAX_PAIR);

        new_res.valid_res = ok;
        new_res.year      = ok ? yy       : '0;
        new_res.month     = ok ? mo[3:0]  : '0;
        new_res.day       = ok ? dd       : '0;
        new_res.hour      = ok ? hh       : '0;
        new_res.minute    = ok ? mi       : '0;
        new_res.second    = ok ? ss       : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_position_reg <= '0;
            too_long_reg      <= 1'b0;
            error_seen_reg    <= 1'b0;
            tens_char_reg     <= '0;
            for (int i = 0; i < dtsp_pkg::NUM_FIELDS; i++) field_values_reg[i] <= '0;
        end else if (s_fire) begin
            if (s_end_of_text) begin
                char_position_reg <= '0;
                too_long_reg      <= 1'b0;
                error_seen_reg    <= 1'b0;
                tens_char_reg     <= '0;
                for (int i = 0; i < dtsp_pkg::NUM_FIELDS; i++) field_values_reg[i] <= '0;
            end else begin
                char_position_reg <= char_position_next;
                too_long_reg      <= too_long_next;
                error_seen_reg    <= error_seen_next;
                tens_char_reg     <= tens_char_next;
                field_values_reg  <= field_values_next;
            end
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_fire) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                main_res_reg   <= skid_res_reg;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                main_valid_reg <= 1'b1;
                main_res_reg   <= new_res;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
            skid_res_reg   <= new_res;
        end
    end

    assign m_valid     = main_valid_reg;
    assign m_valid_res = main_res_reg.valid_res;
    assign m_year      = main_res_reg.year;
    assign m_month     = main_res_reg.month;
    assign m_day       = main_res_reg.day;
    assign m_hour      = main_res_reg.hour;
    assign m_minute    = main_res_reg.minute;
    assign m_second    = main_res_reg.second;

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        char_position_reg <= dtsp_pkg::POS_LAST)
        else $error("character position ran past the message length");

    a_too_long_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        too_long_reg |-> (char_position_reg == dtsp_pkg::POS_LAST))
        else $error("overlong flag set before the full length was seen");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_end_of_text) |=> (char_position_reg == '0 && !error_seen_reg))
        else $error("message state not cleared after the final character");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_end_of_text) |=> main_valid_reg)
        else $error("final character transfer produced no result");

endmodule

`default_nettype wire

[test/dtsp_checker.sv]
// Scoreboard for the date-time text parser: tracks every input transfer,
// predicts the parsed result of each message and checks the result channel.
// Depends on dtsp_pkg for the result record and the text layout constants.
module dtsp_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_end_of_text,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_valid_res,
    input  logic [5:0] m_year,
    input  logic [3:0] m_month,
    input  logic [5:0] m_day,
    input  logic [5:0] m_hour,
    input  logic [5:0] m_minute,
    input  logic [5:0] m_second,
    output int         mismatch_count,
    output int         results_pending,
    output int         results_checked,
    output int         valid_results
);

    logic [4:0]        char_pos;
    logic              overlong;
    logic              format_err;
    logic [7:0]        tens_digit;
    logic [5:0]        parsed [6];
    dtsp_pkg::result_t parsed_q [$];
    int                mismatch_total;
    int                checked_total;
    int                valid_total;

    function automatic int digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = c - dtsp_pkg::CHAR_ZERO;
        return int'($signed(d));
    endfunction

    function automatic logic [5:0] month_length(input logic [5:0] mo, input logic [5:0] yy);
        case (mo)
            6'd4, 6'd6, 6'd9, 6'd11: return 6'd30;
            6'd2:                    return (yy % 4 == 0) ? 6'd29 : 6'd28;
            default:                 return 6'd31;
        endcase
    endfunction

    task automatic clear_text();
        char_pos   = '0;
        overlong   = 1'b0;
        format_err = 1'b0;
        tens_digit = '0;
        foreach (parsed[i]) parsed[i] = '0;
    endtask

    task automatic scan_char(input logic [7:0] c, input logic last);
        int                pair;
        logic              ok;
        dtsp_pkg::result_t res;
        if (char_pos >= dtsp_pkg::POS_LAST) begin
            overlong = 1'b1;
        end else begin
            if (char_pos == dtsp_pkg::POS_DASH_A || char_pos == dtsp_pkg::POS_DASH_B) begin
                if (c != dtsp_pkg::CHAR_DASH) format_err = 1'b1;
            end else if (char_pos == dtsp_pkg::POS_SPACE) begin
                if (c != dtsp_pkg::CHAR_SPACE) format_err = 1'b1;
            end else if (char_pos == dtsp_pkg::POS_COLON_A ||
                         char_pos == dtsp_pkg::POS_COLON_B) begin
                if (c != dtsp_pkg::CHAR_COLON) format_err = 1'b1;
            end else if (char_pos % 3 == 0) begin
                tens_digit = c;
            end else begin
                // digits are sign-extended 8-bit offsets, so sums can be negative; only 0..59 pass
                pair = digit_of(tens_digit) * 10 + digit_of(c);
                if (pair >= 0 && pair <= int'(dtsp_pkg::MAX_PAIR))
                    parsed[char_pos / 3] = pair[5:0];
                else
                    format_err = 1'b1;
            end
            char_pos = char_pos + 5'd1;
        end
        if (last) begin
            ok = !format_err && !overlong && char_pos == dtsp_pkg::POS_LAST;
            if (ok) begin
                if (parsed[dtsp_pkg::IDX_MONTH] == 0 ||
                    parsed[dtsp_pkg::IDX_MONTH] > dtsp_pkg::MAX_MONTH)
                    ok = 1'b0;
                else if (parsed[dtsp_pkg::IDX_DAY] == 0 ||
                         parsed[dtsp_pkg::IDX_DAY] > month_length(parsed[dtsp_pkg::IDX_MONTH],
                                                                  parsed[dtsp_pkg::IDX_YEAR]))
                    ok = 1'b0;
                if (parsed[dtsp_pkg::IDX_HOUR] > dtsp_pkg::MAX_HOUR ||
                    parsed[dtsp_pkg::IDX_MINUTE] > dtsp_pkg::MAX_PAIR ||
                    parsed[dtsp_pkg::IDX_SECOND] > dtsp_pkg::MAX_PAIR) ok = 1'b0;
            end
            res = '0;
            if (ok) begin
                res.valid_res = 1'b1;
                res.year      = parsed[dtsp_pkg::IDX_YEAR];
                res.month     = parsed[dtsp_pkg::IDX_MONTH][3:0];
                res.day       = parsed[dtsp_pkg::IDX_DAY];
                res.hour      = parsed[dtsp_pkg::IDX_HOUR];
                res.minute    = parsed[dtsp_pkg::IDX_MINUTE];
                res.second    = parsed[dtsp_pkg::IDX_SECOND];
            end
            parsed_q.push_back(res);
            clear_text();
        end
    endtask

    task automatic flag_mismatch(input string what, input dtsp_pkg::result_t want,
                                 input dtsp_pkg::result_t got);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display({"%s at %0t: expected ok=%0d %0d-%0d-%0d %0d:%0d:%0d,",
                      " got ok=%0d %0d-%0d-%0d %0d:%0d:%0d"},
                     what, $realtime, want.valid_res, want.year, want.month, want.day,
                     want.hour, want.minute, want.second, got.valid_res, got.year,
                     got.month, got.day, got.hour, got.minute, got.second);
    endtask

    always @(posedge aclk) begin
        dtsp_pkg::result_t got;
        dtsp_pkg::result_t want;
        if (!aresetn) begin
            clear_text();
            parsed_q.delete();
            mismatch_total = 0;
            checked_total  = 0;
            valid_total    = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_valid_res, m_year, m_month, m_day, m_hour, m_minute, m_second};
                if (parsed_q.size() == 0) begin
                    flag_mismatch("unexpected result", '0, got);
                end else begin
                    want = parsed_q.pop_front();
                    if (got.valid_res !== want.valid_res || got.year !== want.year ||
                        got.month !== want.month || got.day !== want.day ||
                        got.hour !== want.hour || got.minute !== want.minute ||
                        got.second !== want.second)
                        flag_mismatch("result mismatch", want, got);
                    checked_total++;
                    if (want.valid_res) valid_total++;
                end
            end
            if (s_valid && s_ready) scan_char(s_char_in, s_end_of_text);
        end
        mismatch_count  <= mismatch_total;
        results_pending <= parsed_q.size();
        results_checked <= checked_total;
        valid_results   <= valid_total;
    end

endmodule

[test/tb_datetime_string_parser_unit.sv]
// Top of the date-time text parser testbench: clock, reset, character stimulus
// and result-side back-pressure. Needs dtsp_pkg, the parser and dtsp_checker.
module tb_datetime_string_parser_unit;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_end_of_text;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_valid_res;
    logic [5:0] m_year;
    logic [3:0] m_month;
    logic [5:0] m_day;
    logic [5:0] m_hour;
    logic [5:0] m_minute;
    logic [5:0] m_second;

    int mismatches;
    int pending;
    int checked;
    int valid_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int chars_sent    = 0;
    int texts_sent    = 0;

    logic [7:0] text_q [$];

    datetime_string_parser_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_valid_res   (m_valid_res),
        .m_year        (m_year),
        .m_month       (m_month),
        .m_day         (m_day),
        .m_hour        (m_hour),
        .m_minute      (m_minute),
        .m_second      (m_second)
    );

    dtsp_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second),
        .mismatch_count  (mismatches),
        .results_pending (pending),
        .results_checked (checked),
        .valid_results   (valid_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Called at a falling edge; valid stays up until the transfer happens.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid       <= 1'b0;
            s_char_in     <= 8'($urandom);
            s_end_of_text <= 1'($urandom);
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_in     <= c;
        s_end_of_text <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
        texts_sent++;
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic add_pair(input int v);
        text_q.push_back(8'(dtsp_pkg::CHAR_ZERO + v / 10));
        text_q.push_back(8'(dtsp_pkg::CHAR_ZERO + v % 10));
    endtask

    task automatic build_date(input int yy, mo, dd, hh, mi, ss);
        text_q.delete();
        add_pair(yy); text_q.push_back(dtsp_pkg::CHAR_DASH);
        add_pair(mo); text_q.push_back(dtsp_pkg::CHAR_DASH);
        add_pair(dd); text_q.push_back(dtsp_pkg::CHAR_SPACE);
        add_pair(hh); text_q.push_back(dtsp_pkg::CHAR_COLON);
        add_pair(mi); text_q.push_back(dtsp_pkg::CHAR_COLON);
        add_pair(ss);
    endtask

    // Mostly well-formed dates near the limits, the rest damaged or noise.
    task automatic build_random_text();
        int pick, yy, mo, dd, hh, mi, ss, pos, n;
        pick = $urandom_range(99);
        if (pick >= 93) begin
            text_q.delete();
            n = $urandom_range(1, 24);
            repeat (n) text_q.push_back(8'($urandom));
            return;
        end
        yy = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
        mo = ($urandom_range(9) == 0) ? $urandom_range(13) :
             ($urandom_range(4) == 0) ? 2 : $urandom_range(1, 12);
        dd = ($urandom_range(19) == 0) ? 0 :
             ($urandom_range(2) == 0) ? $urandom_range(27, 32) : $urandom_range(1, 28);
        hh = ($urandom_range(9) == 0) ? $urandom_range(24, 29) : $urandom_range(23);
        mi = ($urandom_range(19) == 0) ? $urandom_range(60, 99) : $urandom_range(59);
        ss = ($urandom_range(19) == 0) ? $urandom_range(60, 99) : $urandom_range(59);
        build_date(yy, mo, dd, hh, mi, ss);
        if (pick >= 85) begin
            n = $urandom_range(1, 5);
            repeat (n) text_q.push_back(8'($urandom));
        end else if (pick >= 75) begin
            n = $urandom_range(1, 16);
            while (text_q.size() > n) void'(text_q.pop_back());
        end else if (pick >= 65) begin
            do pos = $urandom_range(16); while (pos % 3 == 2);
            text_q[pos] = 8'($urandom);
        end else if (pick >= 55) begin
            text_q[3 * $urandom_range(4) + 2] = 8'($urandom);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int char_goal);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (chars_sent < char_goal) begin
            build_random_text();
            send_text();
            if ($urandom_range(24) == 0) hold_until_drained();
        end
        hold_until_drained();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_char_in     = '0;
        s_end_of_text = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 70;
        // leap day with the largest time, then the largest year
        build_date(24, 2, 29, 23, 59, 59);
        send_text();
        build_date(59, 12, 31, 0, 0, 0);
        send_text();
        // zero month and day
        build_date(0, 0, 0, 0, 0, 0);
        send_text();
        // one character too many
        build_date(23, 2, 28, 12, 0, 0);
        text_q.push_back(dtsp_pkg::CHAR_ZERO);
        send_text();
        // single all-ones byte: far too short
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text();
        hold_until_drained();

        run_phase(37, 70, 530);
        run_phase(70, 37, 1060);
        run_phase(0, 0, 1600);
        repeat (8) @(negedge aclk);

        $display("Covered %0d characters in %0d texts: %0d results checked, %0d valid dates.",
                 chars_sent, texts_sent, checked, valid_count);
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
